// ===== src/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg
// shared widths, status codes and beat types for the sequence reorder buffer
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int WINDOW      = 16;
  localparam int HANDLE_BITS = 8;

  localparam int SEQ_W    = 16;
  localparam int HANDLE_W = 8;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STORE_W  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  localparam logic [SEQ_W-1:0]  WIN_SEQ   = SEQ_W'(WINDOW);
  localparam logic [SLOT_W:0]   WIN_SLOT  = (SLOT_W + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [SEQ_W-1:0]  SEQ_MAX   = '1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_STRANDED = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic                released;
    logic [1:0]          status;
    logic                last;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [STORE_W-1:0] wdata;
    logic               re;
    logic [SLOT_W-1:0]  raddr;
  } ram_req_t;

endpackage

// ===== src/sequence_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// parks out-of-order items in a window and releases them in sequence order
// ----------------------------------------------------------------------------
// Each input beat carries a 16-bit sequence number and a buffer handle, or an
// end-of-stream flag in tuser. Items within the window ahead of the expected
// number are parked in a handle memory; every item that continues the expected
// sequence then leaves in order, one result beat per cycle while the output
// does not stall, the final beat of the run marked with tlast. Rejected items
// and end-of-stream reports give one beat. An input beat is taken only while
// no earlier item is in work. Parked entries of a run are read out by the
// drain sequencer, one handle a cycle from the memory's single read port
// while the output does not stall.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // seq_number[15:0], buffer_handle[23:16]
  input  logic        in_tuser,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_seq[15:0], out_handle[23:16]
  output logic [2:0]  out_tuser,  // released[0], status[2:1]
  output logic        out_tlast   // last_of_run
);

  srb_pkg::ram_req_t           ram_req;
  logic [srb_pkg::STORE_W-1:0] ram_rdata;
  logic                        res_valid;
  logic                        res_ready;
  srb_pkg::res_t               res;
  srb_pkg::res_t               out_res;

  srb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_seq    (in_tdata[15:0]),
    .in_handle (in_tdata[23:16]),
    .in_end    (in_tuser),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  srb_ram #(
    .DEPTH (srb_pkg::WINDOW),
    .WIDTH (srb_pkg::STORE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  srb_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.handle, out_res.seq};
  assign out_tuser = {out_res.status, out_res.released};
  assign out_tlast = out_res.last;

endmodule

// ===== src/srb_ram.sv =====
// ----------------------------------------------------------------------------
// srb_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module srb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/srb_ctrl.sv =====
// ----------------------------------------------------------------------------
// srb_ctrl
// window bookkeeping: slot valid bits, expected sequence, in-order drain
// ----------------------------------------------------------------------------
module srb_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srb_pkg::SEQ_W-1:0]    in_seq,
  input  logic [srb_pkg::HANDLE_W-1:0] in_handle,
  input  logic                         in_end,
  output srb_pkg::ram_req_t            ram_req,
  input  logic [srb_pkg::STORE_W-1:0]  ram_rdata,
  output logic                         res_valid,
  output srb_pkg::res_t                res,
  input  logic                         res_ready
);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DRAIN} state_t;

  state_t                        state_r, state_nxt;
  logic [srb_pkg::SEQ_W-1:0]     seq_r, seq_nxt;
  logic [srb_pkg::STORE_W-1:0]   hnd_r, hnd_nxt;
  logic                          end_r, end_nxt;
  logic [srb_pkg::SEQ_W-1:0]     next_exp_r, next_exp_nxt;
  logic [srb_pkg::SLOT_W-1:0]    next_slot_r, next_slot_nxt;
  logic [srb_pkg::WINDOW-1:0]    valid_r, valid_nxt;

  logic [srb_pkg::SEQ_W-1:0]     seq_gap;
  logic                          in_win;
  logic [srb_pkg::SLOT_W:0]      slot_sum;
  logic [srb_pkg::SLOT_W-1:0]    slot;
  logic [srb_pkg::SEQ_W-1:0]     next_exp_inc;
  logic [srb_pkg::SLOT_W-1:0]    slot_inc;
  logic                          run_last;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    seq_gap  = seq_r - next_exp_r;
    in_win   = (seq_gap < srb_pkg::WIN_SEQ);
    slot_sum = {1'b0, next_slot_r} + {1'b0, seq_gap[srb_pkg::SLOT_W-1:0]};
    if (slot_sum >= srb_pkg::WIN_SLOT) begin
      slot = srb_pkg::SLOT_W'(slot_sum - srb_pkg::WIN_SLOT);
    end else begin
      slot = slot_sum[srb_pkg::SLOT_W-1:0];
    end
    next_exp_inc = next_exp_r + 1'b1;
    if (next_exp_r == srb_pkg::SEQ_MAX || next_slot_r == srb_pkg::LAST_SLOT) begin
      slot_inc = '0;
    end else begin
      slot_inc = next_slot_r + 1'b1;
    end
    run_last = !valid_r[slot_inc];
  end

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    hnd_nxt       = hnd_r;
    end_nxt       = end_r;
    next_exp_nxt  = next_exp_r;
    next_slot_nxt = next_slot_r;
    valid_nxt     = valid_r;
    ram_req       = '0;
    res_valid     = 1'b0;
    res           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          seq_nxt   = in_seq;
          hnd_nxt   = in_handle[srb_pkg::STORE_W-1:0];
          end_nxt   = in_end;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (res_ready) begin
          res_valid = 1'b1;
          res.last  = 1'b1;
          state_nxt = S_IDLE;
          if (end_r) begin
            res.seq    = next_exp_r;
            res.status = (|valid_r) ? srb_pkg::ST_STRANDED : srb_pkg::ST_OK;
            valid_nxt  = '0;
          end else if (!in_win || valid_r[slot]) begin
            res.seq    = seq_r;
            res.handle = srb_pkg::HANDLE_W'(hnd_r);
            res.status = srb_pkg::ST_REJECT;
          end else if (seq_gap != '0) begin
            res.seq         = seq_r;
            res.handle      = srb_pkg::HANDLE_W'(hnd_r);
            res.status      = srb_pkg::ST_OK;
            ram_req.we      = 1'b1;
            ram_req.waddr   = slot;
            ram_req.wdata   = hnd_r;
            valid_nxt[slot] = 1'b1;
          end else begin
            // item continues the sequence, release it straight away
            res.seq       = next_exp_r;
            res.handle    = srb_pkg::HANDLE_W'(hnd_r);
            res.released  = 1'b1;
            res.status    = srb_pkg::ST_OK;
            res.last      = run_last;
            next_exp_nxt  = next_exp_inc;
            next_slot_nxt = slot_inc;
            if (!run_last) begin
              ram_req.re    = 1'b1;
              ram_req.raddr = slot_inc;
              state_nxt     = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        if (res_ready) begin
          res_valid              = 1'b1;
          res.seq                = next_exp_r;
          res.handle             = srb_pkg::HANDLE_W'(ram_rdata);
          res.released           = 1'b1;
          res.status             = srb_pkg::ST_OK;
          res.last               = run_last;
          valid_nxt[next_slot_r] = 1'b0;
          next_exp_nxt           = next_exp_inc;
          next_slot_nxt          = slot_inc;
          if (run_last) begin
            state_nxt = S_IDLE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = slot_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_exp_r  <= '0;
      next_slot_r <= '0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      next_exp_r  <= next_exp_nxt;
      next_slot_r <= next_slot_nxt;
      valid_r     <= valid_nxt;
    end
    seq_r <= seq_nxt;
    hnd_r <= hnd_nxt;
    end_r <= end_nxt;
  end

endmodule

// ===== src/srb_out_stage.sv =====
// ----------------------------------------------------------------------------
// srb_out_stage
// registered result beat toward the master side
// ----------------------------------------------------------------------------
module srb_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  srb_pkg::res_t res,
  output logic          res_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output srb_pkg::res_t out_res
);

  logic          valid_r, valid_nxt;
  srb_pkg::res_t res_r, res_nxt;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_ready) begin
      valid_nxt = res_valid;
      if (res_valid) begin
        res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

endmodule

// ===== src/srb_checker.sv =====
// ----------------------------------------------------------------------------
// srb_checker
// port-level checks for the sequence reorder buffer
// ----------------------------------------------------------------------------
module srb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed under stall");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // rejected and stranded reports close their run and release nothing
  a_report_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] == srb_pkg::ST_REJECT
      || out_tuser[2:1] == srb_pkg::ST_STRANDED) |-> out_tlast && !out_tuser[0])
    else $error("report beat not a single closing beat");

  // released beats carry ok status
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == srb_pkg::ST_OK)
    else $error("released beat with non-ok status");

  // release continues the sequence within a run
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[0] && !out_tlast
      |=> !out_tvalid || !out_tuser[0] || out_tdata[15:0] == $past(out_tdata[15:0]) + 16'd1)
    else $error("released sequence not consecutive");

endmodule

bind sequence_reorder_buffer srb_checker u_srb_checker (.*);
